>>> hdl/artdmx_universe_receiver_macros.svh
// Assertion macros for the ArtDmx universe receiver.
// Used by artdmx_universe_receiver.sv; expects clk and arst_n in scope.
`ifndef ARTDMX_UNIVERSE_RECEIVER_MACROS_SVH
`define ARTDMX_UNIVERSE_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ARTDMX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ARTDMX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/artdmx_pkg.sv
// Package of the ArtDmx universe receiver: item structs, status and register codes,
// header layout constants and small helper functions. No dependencies.
`default_nettype none

package artdmx_pkg;

	localparam int unsigned CHANNELS_DEF = 512;
	localparam int unsigned LIGHTS_DEF   = 256;

	localparam logic [9:0]  HEADER_BYTES = 10'd18;
	localparam logic [9:0]  POS_MAX      = 10'd1023;
	localparam logic [15:0] MAX_LENGTH   = 16'd512;
	localparam logic [15:0] MIN_LENGTH   = 16'd2;
	localparam logic [15:0] OPCODE_DMX   = 16'h5000;

	// header byte positions
	localparam logic [9:0] POS_ID_END  = 10'd8;
	localparam logic [9:0] POS_OP_LO   = 10'd8;
	localparam logic [9:0] POS_OP_HI   = 10'd9;
	localparam logic [9:0] POS_PORT_LO = 10'd14;
	localparam logic [9:0] POS_PORT_HI = 10'd15;
	localparam logic [9:0] POS_LEN_HI  = 10'd16;
	localparam logic [9:0] POS_LEN_LO  = 10'd17;

	typedef enum logic [2:0] {
		ST_KEPT      = 3'd0,
		ST_OTHER     = 3'd1,
		ST_SHORT     = 3'd2,
		ST_BAD_ID    = 3'd3,
		ST_BAD_OP    = 3'd4,
		ST_BAD_LEN   = 3'd5,
		ST_TRUNCATED = 3'd6
	} artdmx_status_t;

	typedef enum logic [2:0] {
		REG_NET      = 3'd0,
		REG_SUBNET   = 3'd1,
		REG_UNIVERSE = 3'd2,
		REG_FIRST    = 3'd3,
		REG_COLORS   = 3'd4
	} artdmx_reg_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_GREEN,
		RD_BLUE,
		RD_EMIT
	} artdmx_rd_state_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_COLOR  = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
		logic       last_byte;
		logic [7:0] light_index;
	} artdmx_in_t;

	typedef struct packed {
		logic           result_kind;
		artdmx_status_t status;
		logic           colors_changed;
		logic [7:0]     red;
		logic [7:0]     green;
		logic [7:0]     blue;
	} artdmx_out_t;

	// "Art-Net" followed by a zero byte
	function automatic logic [7:0] id_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h41;
			3'd1: b = 8'h72;
			3'd2: b = 8'h74;
			3'd3: b = 8'h2D;
			3'd4: b = 8'h4E;
			3'd5: b = 8'h65;
			3'd6: b = 8'h74;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic length_ok(input logic [15:0] len);
		return (len >= MIN_LENGTH) && (len <= MAX_LENGTH);
	endfunction

endpackage

`default_nettype wire

>>> hdl/artdmx_universe_receiver.sv
// ArtDmx universe receiver: header parser, staging and committed channel stores,
// commit copy engine and light color readout. Depends on artdmx_pkg and the macro header.
//
// Usage: in_item carries either one UDP payload byte (command 0, last_byte marks the end)
// or a light color read (command 1). out_item carries one status per packet or one color.
// Packet bytes are taken one per cycle; the status is in the output register the cycle
// after the final byte. A color read issues three reads on the single read port of the
// committed store, one on transfer and one each in RD_GREEN and RD_BLUE; the result is loaded
// from RD_EMIT once the output is free, when the next read can already be taken.
// Channel bytes go to a staging store as they arrive. A kept packet is committed by a copy
// engine that moves min(length, CHANNELS) bytes into the committed store, one per cycle;
// color reads and the final byte of the next packet wait for it, other packet bytes keep
// flowing.
// Reset sets the control and configuration registers and clears the committed fill count,
// so every channel reads zero until a packet covering it is committed; no clearing pass.
// While the output is stalled, non-final packet bytes are still accepted; final bytes wait
// until the output register can take their result, and a color read waits in RD_EMIT.
`default_nettype none
`include "artdmx_universe_receiver_macros.svh"

module artdmx_universe_receiver #(
	parameter int unsigned CHANNELS = artdmx_pkg::CHANNELS_DEF,
	parameter int unsigned LIGHTS   = artdmx_pkg::LIGHTS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  artdmx_pkg::artdmx_in_t  in_item,
	output logic                    out_valid,
	input  wire                     out_ready,
	output artdmx_pkg::artdmx_out_t out_item,
	input  wire                     cfg_write,
	input  wire  [2:0]              cfg_index,
	input  wire  [9:0]              cfg_data
);
	import artdmx_pkg::*;

	localparam int unsigned CH_W  = $clog2(CHANNELS);
	localparam int unsigned CNT_W = $clog2(CHANNELS + 1);

	// configuration
	logic [6:0] net_q;
	logic [3:0] subnet_q;
	logic [3:0] universe_q;
	logic [9:0] first_q;
	logic       colors_en_q;

	// packet parser state
	logic [9:0]  pos_q;
	logic        id_ok_q;
	logic [7:0]  op_lo_q, op_hi_q;
	logic [7:0]  port_lo_q;
	logic [6:0]  port_hi_q;
	logic [15:0] len_q;

	logic [9:0]  pos_inc;
	logic        id_nx;
	logic [7:0]  op_lo_nx, op_hi_nx, port_lo_nx;
	logic [6:0]  port_hi_nx;
	logic [15:0] len_nx;
	logic [9:0]  dpos;
	logic        stage_wr;
	logic [10:0] need_bytes;
	artdmx_status_t status_nx;
	logic [CNT_W-1:0] len_cap;
	logic [CNT_W-1:0] cap_minus1;

	// stores
	logic [7:0] mem_s [CHANNELS];
	logic [7:0] mem_c [CHANNELS];
	logic [CNT_W-1:0] fill_q;

	// copy engine
	logic            cp_busy_q;
	logic [CH_W-1:0] cp_ptr_q, cp_end_q;
	logic            cp_wr_s1;
	logic [CH_W-1:0] cp_addr_s1;
	logic [7:0]      cp_data_s1;
	logic            copy_busy;

	// color readout
	artdmx_rd_state_t rd_state_q, rd_state_nx;
	logic [10:0] base_q, base_in, rd_ch, rd_idx;
	logic        light_ok_q, light_ok_in, rd_light_ok;
	logic        rd_issue, rd_ok;
	logic        rd_ok_s1;
	logic [7:0]  rd_data_s1;
	logic [7:0]  red_q, green_q;

	// handshake and output
	logic        acc, acc_byte, acc_last, acc_rd, commit;
	logic        out_free, load_status, load_color;
	logic        out_valid_q;
	artdmx_out_t out_q, out_nx;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q       <= '0;
			subnet_q    <= '0;
			universe_q  <= '0;
			first_q     <= 10'd1;
			colors_en_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NET:      net_q       <= cfg_data[6:0];
				REG_SUBNET:   subnet_q    <= cfg_data[3:0];
				REG_UNIVERSE: universe_q  <= cfg_data[3:0];
				REG_FIRST:    first_q     <= cfg_data;
				REG_COLORS:   colors_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	assign copy_busy  = cp_busy_q | cp_wr_s1;
	assign out_free   = !out_valid_q || out_ready;
	assign load_color = (rd_state_q == RD_EMIT) && out_free;

	always_comb begin
		if (in_item.command == CMD_READ) begin
			in_ready = !copy_busy && ((rd_state_q == RD_IDLE) || load_color);
		end else if (in_item.last_byte) begin
			in_ready = out_free && (rd_state_q == RD_IDLE) && !copy_busy;
		end else begin
			in_ready = 1'b1;
		end
	end

	assign acc      = in_valid && in_ready;
	assign acc_rd   = acc && (in_item.command == CMD_READ);
	assign acc_byte = acc && (in_item.command == CMD_BYTE);
	assign acc_last = acc_byte && in_item.last_byte;
	assign load_status = acc_last;
	assign commit   = acc_last && (status_nx == ST_KEPT);

	// ---------------------------------------------------------------- parser
	always_comb begin
		pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 10'd1;
		id_nx      = id_ok_q;
		op_lo_nx   = op_lo_q;
		op_hi_nx   = op_hi_q;
		port_lo_nx = port_lo_q;
		port_hi_nx = port_hi_q;
		len_nx     = len_q;
		if (pos_q < POS_ID_END) begin
			if (in_item.byte_value != id_byte(pos_q[2:0]))
				id_nx = 1'b0;
		end else if (pos_q == POS_OP_LO) begin
			op_lo_nx = in_item.byte_value;
		end else if (pos_q == POS_OP_HI) begin
			op_hi_nx = in_item.byte_value;
		end else if (pos_q == POS_PORT_LO) begin
			port_lo_nx = in_item.byte_value;
		end else if (pos_q == POS_PORT_HI) begin
			port_hi_nx = in_item.byte_value[6:0];
		end else if (pos_q == POS_LEN_HI) begin
			len_nx = {in_item.byte_value, 8'h00};
		end else if (pos_q == POS_LEN_LO) begin
			len_nx = {len_q[15:8], in_item.byte_value};
		end

		dpos     = pos_q - HEADER_BYTES;
		stage_wr = acc_byte && (pos_q >= HEADER_BYTES) && length_ok(len_q) &&
			({6'd0, dpos} < len_q) && ({1'b0, dpos} < 11'(CHANNELS));

		// length is at most MAX_LENGTH wherever this is used
		need_bytes = 11'(HEADER_BYTES) + {1'b0, len_nx[9:0]};
		if (pos_inc < HEADER_BYTES) begin
			status_nx = ST_SHORT;
		end else if (!id_nx) begin
			status_nx = ST_BAD_ID;
		end else if ({op_hi_nx, op_lo_nx} != OPCODE_DMX) begin
			status_nx = ST_BAD_OP;
		end else if (!length_ok(len_nx)) begin
			status_nx = ST_BAD_LEN;
		end else if ({1'b0, pos_inc} < need_bytes) begin
			status_nx = ST_TRUNCATED;
		end else if (port_lo_nx[3:0] != universe_q || port_lo_nx[7:4] != subnet_q ||
				port_hi_nx != net_q) begin
			status_nx = ST_OTHER;
		end else begin
			status_nx = ST_KEPT;
		end

		len_cap    = ({1'b0, len_nx[9:0]} > 11'(CHANNELS)) ? CNT_W'(CHANNELS) :
			CNT_W'(len_nx[9:0]);
		cap_minus1 = len_cap - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			id_ok_q   <= 1'b1;
			op_lo_q   <= '0;
			op_hi_q   <= '0;
			port_lo_q <= '0;
			port_hi_q <= '0;
			len_q     <= '0;
		end else if (acc_last) begin
			pos_q     <= '0;
			id_ok_q   <= 1'b1;
			op_lo_q   <= '0;
			op_hi_q   <= '0;
			port_lo_q <= '0;
			port_hi_q <= '0;
			len_q     <= '0;
		end else if (acc_byte) begin
			pos_q     <= pos_inc;
			id_ok_q   <= id_nx;
			op_lo_q   <= op_lo_nx;
			op_hi_q   <= op_hi_nx;
			port_lo_q <= port_lo_nx;
			port_hi_q <= port_hi_nx;
			len_q     <= len_nx;
		end
	end

	// staging store; the copy engine reads entry d before the next packet can overwrite it,
	// since that packet's header bytes arrive first, so no interlock is needed on this side
	always_ff @(posedge clk) begin
		if (stage_wr)
			mem_s[dpos[CH_W-1:0]] <= in_item.byte_value;
		if (cp_busy_q)
			cp_data_s1 <= mem_s[cp_ptr_q];
	end

	// ---------------------------------------------------------------- commit copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_busy_q <= 1'b0;
			cp_ptr_q  <= '0;
			cp_end_q  <= '0;
			cp_wr_s1  <= 1'b0;
			fill_q    <= '0;
		end else begin
			cp_wr_s1 <= cp_busy_q;
			if (commit) begin
				cp_busy_q <= 1'b1;
				cp_ptr_q  <= '0;
				cp_end_q  <= cap_minus1[CH_W-1:0];
				if (len_cap > fill_q)
					fill_q <= len_cap;
			end else if (cp_busy_q) begin
				cp_ptr_q <= cp_ptr_q + CH_W'(1);
				if (cp_ptr_q == cp_end_q)
					cp_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_ptr_q;
	end

	// committed store: copy writes, color readout reads
	always_ff @(posedge clk) begin
		if (cp_wr_s1)
			mem_c[cp_addr_s1] <= cp_data_s1;
		if (rd_issue)
			rd_data_s1 <= mem_c[rd_idx[CH_W-1:0]];
	end

	// ---------------------------------------------------------------- color readout
	always_comb begin
		base_in     = {1'b0, first_q} + {2'd0, in_item.light_index, 1'b0} +
			{3'd0, in_item.light_index};
		light_ok_in = {1'b0, in_item.light_index} < 9'(LIGHTS);

		rd_issue    = acc_rd || (rd_state_q == RD_GREEN) || (rd_state_q == RD_BLUE);
		if (rd_state_q == RD_GREEN) begin
			rd_ch       = base_q + 11'd1;
			rd_light_ok = light_ok_q;
		end else if (rd_state_q == RD_BLUE) begin
			rd_ch       = base_q + 11'd2;
			rd_light_ok = light_ok_q;
		end else begin
			rd_ch       = base_in;
			rd_light_ok = light_ok_in;
		end
		rd_idx = rd_ch - 11'd1;
		// channel 0, channels past CHANNELS, lights past LIGHTS and never-committed entries read zero
		rd_ok  = rd_light_ok && (rd_ch != 11'd0) && (rd_ch <= 11'(CHANNELS)) &&
			(rd_idx < 11'(fill_q));
	end

	always_comb begin
		rd_state_nx = rd_state_q;
		case (rd_state_q)
			RD_IDLE:  if (acc_rd) rd_state_nx = RD_GREEN;
			RD_GREEN: rd_state_nx = RD_BLUE;
			RD_BLUE:  rd_state_nx = RD_EMIT;
			RD_EMIT: begin
				if (out_free)
					rd_state_nx = acc_rd ? RD_GREEN : RD_IDLE;
			end
			default:  rd_state_nx = RD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_state_q <= RD_IDLE;
		end else begin
			rd_state_q <= rd_state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rd) begin
			base_q     <= base_in;
			light_ok_q <= light_ok_in;
		end
		if (rd_issue)
			rd_ok_s1 <= rd_ok;
		if (rd_state_q == RD_GREEN)
			red_q <= rd_ok_s1 ? rd_data_s1 : 8'd0;
		if (rd_state_q == RD_BLUE)
			green_q <= rd_ok_s1 ? rd_data_s1 : 8'd0;
	end

	// ---------------------------------------------------------------- output register
	always_comb begin
		out_nx = '0;
		if (load_color) begin
			out_nx.result_kind = KIND_COLOR;
			out_nx.status      = ST_KEPT;
			out_nx.red         = red_q;
			out_nx.green       = green_q;
			out_nx.blue        = rd_ok_s1 ? rd_data_s1 : 8'd0;
		end else begin
			out_nx.result_kind    = KIND_STATUS;
			out_nx.status         = status_nx;
			out_nx.colors_changed = (status_nx == ST_KEPT) && colors_en_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_color || load_status) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_color || load_status)
			out_q <= out_nx;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// ---------------------------------------------------------------- checks
	`ARTDMX_ASSERT_NOW(a_single_writer, load_status, !load_color, "two results loaded at once")
	`ARTDMX_ASSERT_NOW(a_read_vs_copy, rd_issue, !cp_busy_q && !cp_wr_s1, "read during copy")
	`ARTDMX_ASSERT_NOW(a_commit_idle, commit, !copy_busy && (rd_state_q == RD_IDLE), "commit overlap")
	`ARTDMX_ASSERT_NEXT(a_copy_write, cp_busy_q, cp_wr_s1, "copy read without write")

endmodule

`default_nettype wire

>>> tb/artdmx_tb_pkg.sv
// Scoreboard for the ArtDmx universe receiver bench: mirrors the header checks,
// the two channel banks with their per-channel select, and the light color readout.
// Depends on artdmx_pkg for the item structs, status codes and register codes.
package artdmx_tb_pkg;
	import artdmx_pkg::*;

	localparam int unsigned NUM_CHANNELS  = 512;
	localparam int unsigned HDR_LEN       = 18;
	localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;
	localparam logic [7:0]  ARTNET_ID [8] = '{8'h41, 8'h72, 8'h74, 8'h2D,
		8'h4E, 8'h65, 8'h74, 8'h00};

	class universe_mirror;
		logic [6:0]  net_sel;
		logic [3:0]  subnet_sel;
		logic [3:0]  universe_sel;
		logic [9:0]  first_ch;
		logic        colors_on;

		logic [9:0]  pos;
		logic        id_ok;
		logic [7:0]  op_lo;
		logic [7:0]  op_hi;
		logic [7:0]  port_lo;
		logic [6:0]  port_hi;
		logic [15:0] dmx_len;
		logic [7:0]  bank [2][NUM_CHANNELS];
		logic        live [NUM_CHANNELS];

		artdmx_out_t due_reports[$];
		int unsigned mismatches;

		function new();
			net_sel = '0;
			subnet_sel = '0;
			universe_sel = '0;
			first_ch = 10'd1;
			colors_on = 1'b1;
			foreach (live[c]) begin
				live[c] = 1'b0;
				bank[0][c] = 8'h00;
				bank[1][c] = 8'h00;
			end
			clear_packet();
			mismatches = 0;
		endfunction

		function void clear_packet();
			pos = '0;
			id_ok = 1'b1;
			op_lo = '0;
			op_hi = '0;
			port_lo = '0;
			port_hi = '0;
			dmx_len = '0;
		endfunction

		function void set_register(artdmx_reg_t idx, logic [9:0] val);
			case (idx)
				REG_NET:      net_sel = val[6:0];
				REG_SUBNET:   subnet_sel = val[3:0];
				REG_UNIVERSE: universe_sel = val[3:0];
				REG_FIRST:    first_ch = val;
				REG_COLORS:   colors_on = val[0];
				default: ;
			endcase
		endfunction

		function bit length_in_range();
			return dmx_len >= 16'd2 && dmx_len <= 16'd512;
		endfunction

		// 1-based channel of the committed data; outside 1..512 reads zero
		function logic [7:0] channel_value(int unsigned ch);
			if (ch == 0 || ch > NUM_CHANNELS)
				return 8'h00;
			return bank[live[ch - 1]][ch - 1];
		endfunction

		function void apply_input(artdmx_in_t it);
			artdmx_out_t    rep;
			artdmx_status_t st;
			int unsigned    base;
			int unsigned    d;
			int unsigned    c;
			rep = '0;
			if (it.command == CMD_READ) begin
				// status and change flag stay zero on a color result
				base = 32'(first_ch) + 32'd3 * 32'(it.light_index);
				rep.result_kind = KIND_COLOR;
				rep.red = channel_value(base);
				rep.green = channel_value(base + 1);
				rep.blue = channel_value(base + 2);
				due_reports.push_back(rep);
				return;
			end

			if (pos < 10'd8) begin
				if (it.byte_value != ARTNET_ID[pos[2:0]])
					id_ok = 1'b0;
			end else begin
				case (pos)
					10'd8:  op_lo = it.byte_value;
					10'd9:  op_hi = it.byte_value;
					10'd14: port_lo = it.byte_value;
					10'd15: port_hi = it.byte_value[6:0];
					10'd16: dmx_len = {it.byte_value, 8'h00};
					10'd17: dmx_len[7:0] = it.byte_value;
					default: if (pos >= HDR_LEN) begin
						// channel data is staged in the bank not currently selected
						d = pos - HDR_LEN;
						if (length_in_range() && d < dmx_len && d < NUM_CHANNELS)
							bank[!live[d]][d] = it.byte_value;
					end
				endcase
			end
			if (pos != 10'h3FF)
				pos++;
			if (!it.last_byte)
				return;

			if (pos < HDR_LEN)
				st = ST_SHORT;
			else if (!id_ok)
				st = ST_BAD_ID;
			else if ({op_hi, op_lo} != ARTDMX_OPCODE)
				st = ST_BAD_OP;
			else if (!length_in_range())
				st = ST_BAD_LEN;
			else if (32'(pos) < HDR_LEN + 32'(dmx_len))
				st = ST_TRUNCATED;
			else if (port_lo != {subnet_sel, universe_sel} || port_hi != net_sel)
				st = ST_OTHER;
			else
				st = ST_KEPT;

			if (st == ST_KEPT) begin
				for (c = 0; c < dmx_len && c < NUM_CHANNELS; c++)
					live[c] = !live[c];
			end
			rep.result_kind = KIND_STATUS;
			rep.status = st;
			rep.colors_changed = (st == ST_KEPT) && colors_on;
			due_reports.push_back(rep);
			clear_packet();
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(artdmx_out_t got);
			artdmx_out_t want;
			if (due_reports.size() == 0) begin
				$error("result with nothing outstanding: kind %0d status %0d",
					got.result_kind, got.status);
				mismatches++;
				return;
			end
			want = due_reports.pop_front();
			compare_field("result_kind", want.result_kind, got.result_kind);
			compare_field("status", want.status, got.status);
			compare_field("colors_changed", want.colors_changed, got.colors_changed);
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
		endfunction
	endclass

endpackage

>>> tb/testbench.sv
// Bench for artdmx_universe_receiver: directed and random ArtDmx packets mixed with
// light color reads, with random sender gaps and receiver stalls, checked by universe_mirror.
// Depends on artdmx_pkg, artdmx_tb_pkg and the receiver RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import artdmx_pkg::*;
	import artdmx_tb_pkg::*;

	typedef enum int {
		FLAW_NONE,
		FLAW_SHORT,
		FLAW_ID,
		FLAW_OPCODE,
		FLAW_LENGTH,
		FLAW_TRUNC,
		FLAW_PORT,
		FLAW_NOISE
	} packet_flaw_t;

	localparam int unsigned SETTLE_CYCLES = 600;   // full-universe commit copy plus a read
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned RANDOM_ITEMS  = 600;   // random traffic beside the directed part
	localparam int unsigned HOLD_CYCLES   = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	artdmx_in_t  in_item;
	logic        out_valid;
	logic        out_ready;
	artdmx_out_t out_item;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [9:0]  cfg_data;

	universe_mirror mirror;
	int unsigned    max_gap;
	int unsigned    ready_pct;
	int unsigned    burst_left;
	int unsigned    items_sent;
	bit             hold_off;

	artdmx_universe_receiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_report(out_item);
	end

	// receiver: stretches of steady or choppy ready chosen at random, plus one long hold-off
	initial begin : receiver
		int unsigned stretch;
		bit          choppy;
		out_ready = 1'b0;
		forever begin
			stretch = $urandom_range(5, 60);
			choppy = $urandom_range(0, 2) != 0;
			repeat (stretch) begin
				@(negedge clk);
				if (hold_off) begin
					out_ready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_off = 1'b0;
				end
				out_ready = choppy ? ($urandom_range(0, 99) < ready_pct) : 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// one transfer on the input channel, then maybe a gap between bursts
	task automatic send_item(input artdmx_in_t it, input bit counted = 1'b1);
		int unsigned gap;
		@(negedge clk);
		in_item = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		mirror.apply_input(it);
		if (counted)
			items_sent++;
		if (burst_left != 0)
			burst_left--;
		else if (max_gap != 0) begin
			gap = $urandom_range(1, max_gap);
			burst_left = $urandom_range(1, 40);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_read(input logic [7:0] light);
		artdmx_in_t it;
		it.command = CMD_READ;
		it.byte_value = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.light_index = light;
		send_item(it);
	endtask

	// mostly lights whose three channels lie inside the universe
	function automatic logic [7:0] pick_light();
		int unsigned span;
		span = (mirror.first_ch <= 10'd510) ? (510 - mirror.first_ch) / 3 : 0;
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, span));
	endfunction

	// body is the data byte count; for a short packet it is the total byte count
	task automatic send_packet(input packet_flaw_t flaw, input int unsigned len_field,
			input int unsigned body, input int unsigned read_pct);
		logic [7:0]  pkt[$];
		artdmx_in_t  it;
		int unsigned k;
		int unsigned n;
		logic [7:0]  flip;
		for (k = 0; k < 8; k++)
			pkt.push_back(ARTNET_ID[k]);
		pkt.push_back(ARTDMX_OPCODE[7:0]);
		pkt.push_back(ARTDMX_OPCODE[15:8]);
		pkt.push_back(8'h00);
		pkt.push_back(8'd14);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back({mirror.subnet_sel, mirror.universe_sel});
		pkt.push_back({1'($urandom), mirror.net_sel});   // top bit is not part of the net
		pkt.push_back(len_field[15:8]);
		pkt.push_back(len_field[7:0]);
		if (flaw != FLAW_SHORT)
			repeat (body) pkt.push_back(8'($urandom));
		flip = 8'($urandom_range(1, 255));
		case (flaw)
			FLAW_ID: begin
				k = $urandom_range(0, 7);
				pkt[k] = pkt[k] ^ flip;
			end
			FLAW_OPCODE: begin
				k = $urandom_range(8, 9);
				pkt[k] = pkt[k] ^ flip;
			end
			FLAW_PORT: begin
				if ($urandom_range(0, 1))
					pkt[14] = pkt[14] ^ flip;
				else
					pkt[15] = pkt[15] ^ 8'($urandom_range(1, 127));
			end
			FLAW_SHORT: begin
				while (pkt.size() > body)
					void'(pkt.pop_back());
			end
			FLAW_NOISE: begin
				n = $urandom_range(1, 40);
				pkt.delete();
				repeat (n) pkt.push_back(8'($urandom));
			end
			default: ;
		endcase

		for (k = 0; k < pkt.size(); k++) begin
			if ($urandom_range(0, 99) < read_pct)
				send_read(pick_light());
			it.command = CMD_BYTE;
			it.byte_value = pkt[k];
			it.last_byte = (k == pkt.size() - 1);
			it.light_index = 8'($urandom);
			// bytes past the data are ignored by the block
			send_item(it, k < HDR_LEN + len_field || k == pkt.size() - 1);
		end
	endtask

	task automatic send_random_packet();
		packet_flaw_t flaw;
		int unsigned  pick;
		int unsigned  len;
		int unsigned  body;
		int unsigned  rd;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			flaw = FLAW_NONE;
		else if (pick < 61)
			flaw = FLAW_SHORT;
		else if (pick < 67)
			flaw = FLAW_ID;
		else if (pick < 73)
			flaw = FLAW_OPCODE;
		else if (pick < 79)
			flaw = FLAW_LENGTH;
		else if (pick < 86)
			flaw = FLAW_TRUNC;
		else if (pick < 94)
			flaw = FLAW_PORT;
		else
			flaw = FLAW_NOISE;
		// mostly small universes, now and then a nearly full one
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(400, 512) : $urandom_range(2, 40);
		body = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
		case (flaw)
			FLAW_SHORT:  body = $urandom_range(1, 17);
			FLAW_TRUNC:  body = $urandom_range(0, len - 1);
			FLAW_LENGTH: begin
				len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(513, 65535);
				body = $urandom_range(0, 24);
			end
			default: ;
		endcase
		rd = ($urandom_range(0, 3) == 0) ? 10 : 0;
		send_packet(flaw, len, body, rd);
	endtask

	task automatic random_phase(input int unsigned quota);
		int unsigned stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6)) send_read(pick_light());
			else
				send_random_packet();
		end
	endtask

	// drop valid, let every result drain, then cover a commit still being copied
	task automatic wait_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (mirror.due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input artdmx_reg_t idx, input logic [9:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		mirror.set_register(idx, val);
	endtask

	task automatic configure(input logic [6:0] net, input logic [3:0] subnet,
			input logic [3:0] universe, input logic [9:0] first, input logic colors);
		write_register(REG_NET, {3'b000, net});
		write_register(REG_SUBNET, {6'b000000, subnet});
		write_register(REG_UNIVERSE, {6'b000000, universe});
		write_register(REG_FIRST, first);
		write_register(REG_COLORS, {9'b000000000, colors});
	endtask

	initial begin : main
		int unsigned ph;
		mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_write = 1'b0;
		cfg_index = REG_NET;
		cfg_data = '0;
		hold_off = 1'b0;
		max_gap = 0;
		ready_pct = 100;
		burst_left = 0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cases on the reset register values
		max_gap = 3;
		ready_pct = 60;
		send_read(8'd0);
		send_read(8'd255);
		send_packet(FLAW_NONE, 64, 64, 5);      // reads inside see only committed data
		send_read(8'd0);
		send_read(8'd1);
		send_read(8'd170);                       // third channel lies past the universe
		send_read(8'd255);
		send_packet(FLAW_SHORT, 0, 1, 0);
		send_packet(FLAW_SHORT, 0, 17, 0);
		send_packet(FLAW_ID, 4, 4, 0);
		send_packet(FLAW_OPCODE, 4, 4, 0);
		send_packet(FLAW_LENGTH, 0, 3, 0);
		send_packet(FLAW_LENGTH, 1, 3, 0);
		send_packet(FLAW_LENGTH, 513, 3, 0);
		send_packet(FLAW_LENGTH, 65535, 2, 0);
		send_packet(FLAW_TRUNC, 20, 10, 0);
		send_packet(FLAW_PORT, 6, 6, 0);
		send_read(8'd0);
		send_packet(FLAW_NONE, 2, 8, 0);         // trailing bytes after the data
		send_packet(FLAW_NONE, 512, 1030, 0);    // full universe, byte counter saturates
		send_read(8'd0);
		send_read(8'd169);
		wait_quiet();

		// all-ones port address, last channel, change flag off
		configure(7'h7F, 4'hF, 4'hF, 10'd512, 1'b0);
		max_gap = 0;
		ready_pct = 100;
		random_phase(RANDOM_ITEMS / 6);
		wait_quiet();

		configure(7'h00, 4'h0, 4'h0, 10'd1, 1'b1);
		max_gap = 8;
		ready_pct = 30;
		random_phase(RANDOM_ITEMS / 6);
		wait_quiet();

		for (ph = 0; ph < 4; ph++) begin
			configure(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)),
				10'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 512)
					: $urandom_range(1, 64)),
				1'($urandom_range(0, 1)));
			// first phase of this loop: receiver holds off while the sender keeps pushing
			hold_off = (ph == 0);
			max_gap = $urandom_range(0, 6);
			ready_pct = $urandom_range(25, 100);
			random_phase(RANDOM_ITEMS / 6);
			wait_quiet();
		end

		if (mirror.due_reports.size() != 0) begin
			$error("%0d results never arrived", mirror.due_reports.size());
			mirror.mismatches++;
		end
		if (mirror.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> artdmx_universe_receiver.f
+incdir+hdl
hdl/artdmx_pkg.sv
hdl/artdmx_universe_receiver.sv
tb/artdmx_tb_pkg.sv
tb/testbench.sv
